[rtl/core/cawp_pkg.sv]
package cawp_pkg;

  // Field widths of the frame, the result and the configuration registers.
  localparam int ID_W     = 11;
  localparam int DLC_W    = 4;
  localparam int TIDX_W   = 2;
  localparam int CNT_W    = 10;

  // Block dimensions.
  localparam int NUM_TARGETS = 4;
  localparam int MAX_SLOTS   = 256;
  localparam int WIN_W       = 16;
  localparam int SLOT_W      = $clog2(MAX_SLOTS);
  localparam int CNTC_W      = SLOT_W + 1;
  localparam int COUNTS_W    = NUM_TARGETS * CNT_W;

  // Bits added per frame with a lower identifier than the target: dlc * 8 + FRAME_OVERHEAD.
  localparam int ADD_W          = 8;
  localparam int FRAME_OVERHEAD = 47;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_ID_0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_ID_1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_ID_2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_ID_3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INST_COUNTS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_WINDOW    = 3'd5;

  localparam logic [ID_W-1:0]     RST_TARGET_ID_0 = 11'd417;
  localparam logic [ID_W-1:0]     RST_TARGET_ID_1 = 11'd451;
  localparam logic [ID_W-1:0]     RST_TARGET_ID_2 = 11'd707;
  localparam logic [ID_W-1:0]     RST_TARGET_ID_3 = 11'd977;
  localparam logic [COUNTS_W-1:0] RST_INST_COUNTS = 40'd53792153800;
  localparam logic [WIN_W-1:0]    RST_MIN_WINDOW  = 16'd222;

  // Queue between the classifier and the slot update.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef logic [NUM_TARGETS-1:0][ID_W-1:0] id_vec_t;

  // One request for the slot update: per target, whether the frame closed
  // its window, the slot, the closed window and whether the slots wrapped.
  typedef struct packed {
    logic [NUM_TARGETS-1:0]             hit;
    logic [NUM_TARGETS-1:0]             wrap;
    logic [NUM_TARGETS-1:0][SLOT_W-1:0] slot;
    logic [NUM_TARGETS-1:0][WIN_W-1:0]  win;
  } req_t;

endpackage

[rtl/core/can_attack_window_profiler.sv]
// CAN attack window profiler. Each request on the frame channel carries one
// observed CAN frame (identifier and data length code) and produces exactly
// one request on the result channel, in order. For each of four watched
// identifiers the block keeps a running window of bus traffic: a frame with a
// higher identifier clears it, a lower one adds dlc*8+47 bits (saturating at
// 65535), and the watched identifier itself closes the window into the
// current per-period instance slot, storing it on the first pass and keeping
// the minimum afterwards. The result names the lowest matching target, the
// slot, the slot's new value and whether it reaches min_window_bits. The
// frame channel takes a new frame every cycle until a two-entry request queue
// fills. After that the pace is set by the slot memories: a request leaves
// the queue only after the one before it is written back and its result
// registered. A frame passes through the request queue, the slot read and
// the result registers. Slots hold no reset value: a slot is meaningful
// only once it has been written in the current configuration. Configuration
// registers are written through cfg_valid/cfg_ready (always ready) and must
// only be changed while no frame is in flight.
module can_attack_window_profiler (
  input  logic                              clk,
  input  logic                              rst,
  // Frame channel.
  input  logic                              frame_valid,
  output logic                              frame_stall,
  input  logic [cawp_pkg::ID_W-1:0]         frame_id,
  input  logic [cawp_pkg::DLC_W-1:0]        frame_dlc,
  // Result channel.
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic                              matched,
  output logic [cawp_pkg::TIDX_W-1:0]       target_index,
  output logic [cawp_pkg::SLOT_W-1:0]       slot_index,
  output logic [cawp_pkg::WIN_W-1:0]        window_bits,
  output logic                              attackable,
  // Configuration write channel.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cawp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cawp_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import cawp_pkg::*;

  id_vec_t             target_ids;
  logic [COUNTS_W-1:0] instance_counts;
  logic [WIN_W-1:0]    min_window_bits;

  logic q_full;
  logic q_empty;
  logic q_pop;
  logic accept;
  req_t req;
  req_t head;

  // The registers are plain flops, so a write is always taken at once.
  assign cfg_ready = 1'b1;

  // The front end stalls only when the request queue has no room.
  assign frame_stall = q_full;
  assign accept      = frame_valid && !frame_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_ids[0]   <= RST_TARGET_ID_0;
      target_ids[1]   <= RST_TARGET_ID_1;
      target_ids[2]   <= RST_TARGET_ID_2;
      target_ids[3]   <= RST_TARGET_ID_3;
      instance_counts <= RST_INST_COUNTS;
      min_window_bits <= RST_MIN_WINDOW;
    end else if (cfg_valid && cfg_ready) begin
      // Writes to indexes beyond the register list are dropped.
      case (cfg_index) inside
        REG_TARGET_ID_0, REG_TARGET_ID_1, REG_TARGET_ID_2, REG_TARGET_ID_3: begin
          target_ids[cfg_index[TIDX_W-1:0]] <= cfg_data[ID_W-1:0];
        end
        REG_INST_COUNTS: begin
          instance_counts <= cfg_data[COUNTS_W-1:0];
        end
        REG_MIN_WINDOW: begin
          min_window_bits <= cfg_data[WIN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // The front end classifies each frame against every target and updates the
  // running windows and slot pointers in the cycle it is accepted.
  cawp_front u_front (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .frame_id        (frame_id),
    .frame_dlc       (frame_dlc),
    .target_ids      (target_ids),
    .instance_counts (instance_counts),
    .req             (req)
  );

  cawp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (req),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (head)
  );

  // The back end owns the slot memories, one per target, and performs the
  // read-modify-write for every target the frame matched.
  cawp_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_empty         (q_empty),
    .head            (head),
    .pop             (q_pop),
    .min_window_bits (min_window_bits),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .matched         (matched),
    .target_index    (target_index),
    .slot_index      (slot_index),
    .window_bits     (window_bits),
    .attackable      (attackable)
  );

endmodule

[rtl/core/cawp_front.sv]
module cawp_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic [cawp_pkg::ID_W-1:0]       frame_id,
  input  logic [cawp_pkg::DLC_W-1:0]      frame_dlc,
  input  cawp_pkg::id_vec_t               target_ids,
  input  logic [cawp_pkg::COUNTS_W-1:0]   instance_counts,
  output cawp_pkg::req_t                  req
);
  import cawp_pkg::*;

  logic [NUM_TARGETS-1:0][WIN_W-1:0]  running_window, running_window_next;
  logic [NUM_TARGETS-1:0][SLOT_W-1:0] slot_pointer, slot_pointer_next;
  logic [NUM_TARGETS-1:0]             wrapped_once, wrapped_once_next;

  logic [NUM_TARGETS-1:0][CNT_W-1:0]  cnt_raw;
  logic [NUM_TARGETS-1:0][CNTC_W-1:0] cnt;
  logic [NUM_TARGETS-1:0][SLOT_W-1:0] slot;
  logic [NUM_TARGETS-1:0][CNTC_W-1:0] slot_inc;
  logic [NUM_TARGETS-1:0][WIN_W:0]    sum;
  logic [ADD_W-1:0]                   add;

  always_comb begin
    add = ADD_W'({frame_dlc, 3'b000}) + ADD_W'(FRAME_OVERHEAD);
    for (int t = 0; t < NUM_TARGETS; t++) begin
      cnt_raw[t] = instance_counts[t*CNT_W +: CNT_W];
      cnt[t]     = (cnt_raw[t] > CNT_W'(MAX_SLOTS)) ? CNTC_W'(MAX_SLOTS)
                                                    : cnt_raw[t][CNTC_W-1:0];
      // A pointer left beyond a lowered count falls back to slot 0.
      slot[t]     = ({1'b0, slot_pointer[t]} < cnt[t]) ? slot_pointer[t] : '0;
      slot_inc[t] = {1'b0, slot[t]} + CNTC_W'(1);
      sum[t]      = {1'b0, running_window[t]} + (WIN_W+1)'(add);

      running_window_next[t] = running_window[t];
      slot_pointer_next[t]   = slot_pointer[t];
      wrapped_once_next[t]   = wrapped_once[t];
      req.hit[t]  = 1'b0;
      req.wrap[t] = wrapped_once[t];
      req.slot[t] = slot[t];
      req.win[t]  = running_window[t];

      if (cnt[t] != '0) begin
        if (frame_id > target_ids[t]) begin
          running_window_next[t] = '0;
        end else if (frame_id < target_ids[t]) begin
          running_window_next[t] = sum[t][WIN_W] ? '1 : sum[t][WIN_W-1:0];
        end else begin
          req.hit[t] = 1'b1;
          running_window_next[t] = '0;
          if (slot_inc[t] >= cnt[t]) begin
            slot_pointer_next[t] = '0;
            wrapped_once_next[t] = 1'b1;
          end else begin
            slot_pointer_next[t] = slot_inc[t][SLOT_W-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_window <= '0;
      slot_pointer   <= '0;
      wrapped_once   <= '0;
    end else if (accept) begin
      running_window <= running_window_next;
      slot_pointer   <= slot_pointer_next;
      wrapped_once   <= wrapped_once_next;
    end
  end

endmodule

[rtl/core/cawp_queue.sv]
module cawp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cawp_pkg::req_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output cawp_pkg::req_t head
);
  import cawp_pkg::*;

  req_t              entry [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W+1)'(QDEPTH));
  assign empty = (count == '0);
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

[rtl/core/cawp_back.sv]
module cawp_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_empty,
  input  cawp_pkg::req_t               head,
  output logic                         pop,
  input  logic [cawp_pkg::WIN_W-1:0]   min_window_bits,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic                         matched,
  output logic [cawp_pkg::TIDX_W-1:0]  target_index,
  output logic [cawp_pkg::SLOT_W-1:0]  slot_index,
  output logic [cawp_pkg::WIN_W-1:0]   window_bits,
  output logic                         attackable
);
  import cawp_pkg::*;

  logic                              busy;
  req_t                              cur;
  logic [NUM_TARGETS-1:0][WIN_W-1:0] rdata;
  logic [NUM_TARGETS-1:0][WIN_W-1:0] v;
  logic                              done;

  logic              res_matched;
  logic [TIDX_W-1:0] res_index;
  logic [SLOT_W-1:0] res_slot;
  logic [WIN_W-1:0]  res_win;

  // The read goes out when a request leaves the queue; the write and the
  // result follow in the next cycle or later, before the next read.
  assign pop  = !busy && !q_empty;
  assign done = busy && (!result_valid || !result_stall);

  for (genvar t = 0; t < NUM_TARGETS; t++) begin : g_bank
    logic [WIN_W-1:0] bank [MAX_SLOTS];

    always_ff @(posedge clk) begin
      if (pop) begin
        rdata[t] <= bank[head.slot[t]];
      end
      if (done && cur.hit[t]) begin
        bank[cur.slot[t]] <= v[t];
      end
    end

    assign v[t] = (cur.wrap[t] && (rdata[t] < cur.win[t])) ? rdata[t] : cur.win[t];
  end

  always_comb begin
    res_matched = 1'b0;
    res_index   = '0;
    res_slot    = '0;
    res_win     = '0;
    for (int t = NUM_TARGETS - 1; t >= 0; t--) begin
      if (cur.hit[t]) begin
        res_matched = 1'b1;
        res_index   = TIDX_W'(t);
        res_slot    = cur.slot[t];
        res_win     = v[t];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (done) begin
      matched      <= res_matched;
      target_index <= res_index;
      slot_index   <= res_slot;
      window_bits  <= res_win;
      attackable   <= res_matched && (res_win >= min_window_bits);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
      end else if (done) begin
        busy <= 1'b0;
      end
      if (done) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

[tb/window_check_pkg.sv]
package window_check_pkg;
  import cawp_pkg::*;

  typedef struct packed {
    logic              matched;
    logic [TIDX_W-1:0] target_index;
    logic [SLOT_W-1:0] slot_index;
    logic [WIN_W-1:0]  window_bits;
    logic              attackable;
  } window_result_t;

  localparam int unsigned WIN_SAT = (1 << WIN_W) - 1;

  // Tracks the profiler state for every accepted frame and checks the results.
  class window_scoreboard;
    logic [ID_W-1:0]     target_id [NUM_TARGETS];
    logic [COUNTS_W-1:0] inst_counts;
    logic [WIN_W-1:0]    min_window;

    int unsigned running_window [NUM_TARGETS];
    int unsigned slot_pointer [NUM_TARGETS];
    bit          wrapped [NUM_TARGETS];
    // Slots are always written in order from zero, so the written ones form a prefix.
    int unsigned written_span [NUM_TARGETS];
    logic [WIN_W-1:0] slot_window [NUM_TARGETS][MAX_SLOTS];

    window_result_t expected_results [$];
    int mismatches;

    function new();
      target_id[0] = RST_TARGET_ID_0;
      target_id[1] = RST_TARGET_ID_1;
      target_id[2] = RST_TARGET_ID_2;
      target_id[3] = RST_TARGET_ID_3;
      inst_counts = RST_INST_COUNTS;
      min_window = RST_MIN_WINDOW;
      for (int t = 0; t < NUM_TARGETS; t++) begin
        running_window[t] = 0;
        slot_pointer[t] = 0;
        wrapped[t] = 1'b0;
        written_span[t] = 0;
      end
      mismatches = 0;
    endfunction

    function int unsigned count_of(int t);
      int unsigned c;
      c = inst_counts[t*CNT_W +: CNT_W];
      return (c > MAX_SLOTS) ? MAX_SLOTS : c;
    endfunction

    // Limits a requested count so that a wrapped target never reaches an unwritten slot.
    function int unsigned safe_count(int t, int unsigned field);
      int unsigned clamped;
      clamped = (field > MAX_SLOTS) ? MAX_SLOTS : field;
      if (field != 0 && wrapped[t] && clamped > written_span[t]) return written_span[t];
      return field;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_TARGET_ID_0: target_id[0] = data[ID_W-1:0];
        REG_TARGET_ID_1: target_id[1] = data[ID_W-1:0];
        REG_TARGET_ID_2: target_id[2] = data[ID_W-1:0];
        REG_TARGET_ID_3: target_id[3] = data[ID_W-1:0];
        REG_INST_COUNTS: inst_counts = data[COUNTS_W-1:0];
        REG_MIN_WINDOW:  min_window = data[WIN_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_frame(logic [ID_W-1:0] id, logic [DLC_W-1:0] dlc);
      int unsigned add, cnt, slot, v, nxt;
      window_result_t r;
      add = int'(dlc) * 8 + FRAME_OVERHEAD;
      r = '0;
      for (int t = 0; t < NUM_TARGETS; t++) begin
        cnt = count_of(t);
        if (cnt == 0) continue;
        if (id > target_id[t]) begin
          running_window[t] = 0;
        end else if (id < target_id[t]) begin
          v = running_window[t] + add;
          running_window[t] = (v > WIN_SAT) ? WIN_SAT : v;
        end else begin
          slot = (slot_pointer[t] < cnt) ? slot_pointer[t] : 0;
          v = running_window[t];
          if (wrapped[t] && slot_window[t][slot] < v) v = slot_window[t][slot];
          slot_window[t][slot] = WIN_W'(v);
          if (slot + 1 > written_span[t]) written_span[t] = slot + 1;
          running_window[t] = 0;
          nxt = slot + 1;
          if (nxt >= cnt) begin
            nxt = 0;
            wrapped[t] = 1'b1;
          end
          slot_pointer[t] = nxt;
          if (!r.matched) begin
            r.matched = 1'b1;
            r.target_index = TIDX_W'(t);
            r.slot_index = SLOT_W'(slot);
            r.window_bits = WIN_W'(v);
          end
        end
      end
      r.attackable = r.matched && (r.window_bits >= min_window);
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(window_result_t got);
      window_result_t want;
      if (expected_results.size() == 0) begin
        $error("result accepted with no frame pending");
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("matched", want.matched, got.matched);
      compare_field("target_index", want.target_index, got.target_index);
      compare_field("slot_index", want.slot_index, got.slot_index);
      compare_field("window_bits", want.window_bits, got.window_bits);
      compare_field("attackable", want.attackable, got.attackable);
    endfunction
  endclass

endpackage

[tb/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cawp_pkg::*;
  import window_check_pkg::*;

  // Each side waits up to this many cycles before every request.
  localparam int WAIT_MAX = 19;
  // The receiver holds off once for a long stretch, at this result number,
  // which falls inside the long saturation phase so the sender keeps offering.
  localparam int HOLD_OFF_AT     = 200;
  localparam int HOLD_OFF_CYCLES = 300;
  // Cycles without any accepted request before the run is declared hung.
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 10;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [ID_W-1:0]      ID_MAX = '1;
  localparam int unsigned          CNT_FIELD_MAX = (1 << CNT_W) - 1;

  logic                  clk;
  logic                  rst;
  logic                  frame_valid;
  logic                  frame_stall;
  logic [ID_W-1:0]       frame_id;
  logic [DLC_W-1:0]      frame_dlc;
  logic                  result_valid;
  logic                  result_stall;
  logic                  matched;
  logic [TIDX_W-1:0]     target_index;
  logic [SLOT_W-1:0]     slot_index;
  logic [WIN_W-1:0]      window_bits;
  logic                  attackable;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  window_scoreboard sb = new();

  int frames_sent;
  int results_seen;
  bit tx_quiet;
  bit rx_quiet;

  can_attack_window_profiler u_dut (
    .clk          (clk),
    .rst          (rst),
    .frame_valid  (frame_valid),
    .frame_stall  (frame_stall),
    .frame_id     (frame_id),
    .frame_dlc    (frame_dlc),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .matched      (matched),
    .target_index (target_index),
    .slot_index   (slot_index),
    .window_bits  (window_bits),
    .attackable   (attackable),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // In quiet stretches a side never waits, so back-to-back traffic is covered too.
  function automatic int draw_wait(bit quiet);
    return quiet ? 0 : $urandom_range(0, WAIT_MAX);
  endfunction

  // All driving happens at the falling edge and every request is sampled at
  // the rising edge. A task is entered and left at a falling edge. The frame
  // valid is left high after a request so that a request with no wait keeps it
  // high without a second assignment in the same time step.
  task automatic send_frame(logic [ID_W-1:0] id, logic [DLC_W-1:0] dlc);
    int gap;
    if (frames_sent % 32 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
    gap = draw_wait(tx_quiet);
    if (gap > 0) begin
      frame_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    frame_valid <= 1'b1;
    frame_id <= id;
    frame_dlc <= dlc;
    do @(posedge clk); while (frame_stall);
    sb.note_frame(id, dlc);
    frames_sent++;
    @(negedge clk);
  endtask

  // Like the frame valid, cfg_valid stays high across a batch of writes and
  // the caller lowers it after the last one.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  // Instance counts are limited so that a target that has already wrapped is
  // never pointed at a slot it has not written yet.
  task automatic write_counts(int unsigned c0, int unsigned c1, int unsigned c2,
                              int unsigned c3);
    logic [COUNTS_W-1:0] packed_counts;
    int unsigned want [NUM_TARGETS];
    want = '{c0, c1, c2, c3};
    for (int t = 0; t < NUM_TARGETS; t++) begin
      packed_counts[t*CNT_W +: CNT_W] = CNT_W'(sb.safe_count(t, want[t]));
    end
    write_reg(REG_INST_COUNTS, packed_counts);
  endtask

  // Configuration may only change with nothing in flight. Every frame gives a
  // result, so the block is idle once the last expected result has arrived.
  task automatic wait_drained();
    while (sb.expected_results.size() != 0) @(negedge clk);
  endtask

  // Frame identifiers lean heavily on the watched identifiers and their
  // neighbors, since matches are what drive the slot logic.
  function automatic logic [ID_W-1:0] random_frame_id();
    int t;
    int r;
    r = $urandom_range(0, 99);
    t = $urandom_range(0, NUM_TARGETS - 1);
    if (r < 45) return sb.target_id[t];
    if (r < 60) return sb.target_id[t] + ID_W'($urandom_range(0, 6)) - ID_W'(3);
    if (r < 65) return '0;
    if (r < 70) return ID_MAX;
    return ID_W'($urandom);
  endfunction

  function automatic logic [DLC_W-1:0] random_dlc(bit heavy);
    if (heavy) return ($urandom_range(0, 19) != 0) ? '1 : DLC_W'($urandom);
    if ($urandom_range(0, 4) == 0) return DLC_W'($urandom_range(9, 15));
    return DLC_W'($urandom_range(0, 8));
  endfunction

  // Picks a new setting: extreme and duplicate identifiers, disabled targets,
  // small counts that wrap quickly, the largest count and the threshold
  // extremes. Some registers keep their old value, and now and then a write
  // goes to an unused index.
  task automatic randomize_config();
    int unsigned counts [NUM_TARGETS];
    logic [CFG_DATA_W-1:0] data;
    int r;
    for (int t = 0; t < NUM_TARGETS; t++) begin
      if ($urandom_range(0, 4) != 0) begin
        r = $urandom_range(0, 9);
        data = '0;
        case (r)
          0: data[ID_W-1:0] = '0;
          1: data[ID_W-1:0] = ID_MAX;
          2: data[ID_W-1:0] = sb.target_id[0];
          default: data[ID_W-1:0] = ID_W'($urandom);
        endcase
        if ($urandom_range(0, 3) == 0) begin
          data[CFG_DATA_W-1:ID_W] = (CFG_DATA_W - ID_W)'({$urandom, $urandom});
        end
        write_reg(REG_TARGET_ID_0 + CFG_IDX_W'(t), data);
      end
    end
    for (int t = 0; t < NUM_TARGETS; t++) begin
      r = $urandom_range(0, 9);
      case (r)
        0: counts[t] = 0;
        1: counts[t] = CNT_FIELD_MAX;
        2: counts[t] = $urandom_range(7, 300);
        default: counts[t] = $urandom_range(1, 6);
      endcase
    end
    if (counts[0] == 0 && counts[1] == 0 && counts[2] == 0 && counts[3] == 0) counts[0] = 1;
    write_counts(counts[0], counts[1], counts[2], counts[3]);
    r = $urandom_range(0, 5);
    case (r)
      0: data = '0;
      1: data = CFG_DATA_W'(WIN_SAT);
      2: data = CFG_DATA_W'($urandom);
      default: data = CFG_DATA_W'($urandom_range(50, 700));
    endcase
    write_reg(REG_MIN_WINDOW, data);
    if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, CFG_DATA_W'({$urandom, $urandom}));
    cfg_valid <= 1'b0;
  endtask

  // In the saturation phase one target watches the highest identifier, so no
  // frame can ever clear its window. Mostly long frames push the window up to
  // its ceiling, and only the last few frames close it.
  task automatic run_random_phase(int n, bit saturate);
    logic [ID_W-1:0] id;
    for (int i = 0; i < n; i++) begin
      id = random_frame_id();
      if (saturate) begin
        if (i >= n - 3) id = ID_MAX;
        else if (id == ID_MAX) id = ID_W'($urandom_range(0, ID_MAX - 1));
      end
      send_frame(id, random_dlc(saturate));
    end
    frame_valid <= 1'b0;
  endtask

  task automatic config_saturation();
    for (int t = 0; t < NUM_TARGETS - 1; t++) begin
      write_reg(REG_TARGET_ID_0 + CFG_IDX_W'(t), CFG_DATA_W'($urandom_range(0, ID_MAX - 1)));
    end
    write_reg(REG_TARGET_ID_3, CFG_DATA_W'(ID_MAX));
    write_counts($urandom_range(1, 6), $urandom_range(0, 6), $urandom_range(1, 40), 1);
    write_reg(REG_MIN_WINDOW, CFG_DATA_W'(WIN_SAT));
    cfg_valid <= 1'b0;
  endtask

  // Receiver. For each result it first stalls for a random number of cycles,
  // then takes the next result and hands it to the scoreboard. Once in the run
  // it holds off for a long stretch so the block fills up and stalls frames.
  initial begin
    int hold;
    result_stall = 1'b0;
    do @(negedge clk); while (rst);
    forever begin
      if (results_seen % 32 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
      hold = (results_seen == HOLD_OFF_AT) ? HOLD_OFF_CYCLES : draw_wait(rx_quiet);
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!result_valid);
      sb.check_result(window_result_t'({matched, target_index, slot_index, window_bits,
                                        attackable}));
      results_seen++;
      @(negedge clk);
    end
  end

  // Watchdog. Any accepted request on any channel restarts the count.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (frame_valid && !frame_stall) || (result_valid && !result_stall) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $error("no request accepted for %0d cycles", IDLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  // Main sequence: reset, three directed phases, random phases, then drain.
  initial begin
    rst = 1'b1;
    frame_valid = 1'b0;
    frame_id = '0;
    frame_dlc = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    frames_sent = 0;
    results_seen = 0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset setting. The lowest and highest identifiers and the DLC extremes,
    // a match with an empty window, a window built from three frames that
    // crosses the threshold, and a higher frame clearing every window.
    send_frame('0, '0);
    send_frame(ID_MAX, '1);
    send_frame(RST_TARGET_ID_0, 4'd8);
    send_frame(11'd100, '1);
    send_frame(11'd5, 4'd8);
    send_frame(RST_TARGET_ID_1, 4'd3);
    send_frame(RST_TARGET_ID_3, 4'd9);
    send_frame(11'd1000, '0);
    send_frame(RST_TARGET_ID_2, 4'd4);
    frame_valid <= 1'b0;
    wait_drained();

    // Two targets share one identifier, one target is disabled, another
    // watches the top identifier, and the threshold is zero. The first two identifier
    // writes carry ones in the unused upper bits, which must be dropped.
    write_reg(REG_TARGET_ID_0, {{(CFG_DATA_W - ID_W){1'b1}}, ID_W'(300)});
    write_reg(REG_TARGET_ID_1, {{(CFG_DATA_W - ID_W){1'b1}}, ID_W'(300)});
    write_reg(REG_TARGET_ID_2, '0);
    write_reg(REG_TARGET_ID_3, CFG_DATA_W'(ID_MAX));
    write_counts(2, 1, 0, 3);
    write_reg(REG_MIN_WINDOW, '0);
    cfg_valid <= 1'b0;
    send_frame('0, 4'd2);
    send_frame(11'd300, '1);
    send_frame(11'd12, 4'd1);
    send_frame(11'd300, '0);
    send_frame(ID_MAX, 4'd7);
    send_frame(11'd300, 4'd8);
    send_frame(ID_MAX, '0);
    send_frame(11'd1500, 4'd12);
    frame_valid <= 1'b0;
    wait_drained();

    // The top target's count drops below its slot pointer, so its next match
    // falls back to slot zero. The disabled target comes back with the largest
    // count field, which clamps to the slot limit. A write to an unused index
    // must change nothing, and the threshold sits at its maximum.
    write_counts(2, 1, CNT_FIELD_MAX, 1);
    write_reg(REG_UNUSED, '1);
    write_reg(REG_MIN_WINDOW, CFG_DATA_W'(WIN_SAT));
    cfg_valid <= 1'b0;
    send_frame('0, '1);
    send_frame(ID_MAX, '1);
    send_frame('0, 4'd9);
    send_frame(ID_MAX, 4'd8);
    send_frame(11'd1024, 4'd10);
    frame_valid <= 1'b0;
    wait_drained();

    // Random phases, each with a new setting.
    repeat (3) begin
      randomize_config();
      run_random_phase(40, 1'b0);
      wait_drained();
    end
    config_saturation();
    run_random_phase(430, 1'b1);

    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
